[rtl/core/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes of the round-robin thread scheduler: event codes,
// thread states, result codes, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package rrts_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_JOIN   = 2'd2,
    CMD_EXIT   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_RUN    = 2'd1,
    ST_SLEEP  = 2'd2,
    ST_DONE   = 2'd3
  } tstat_e;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_FULL    = 2'd1,
    RC_NO_JOIN = 2'd2,
    RC_IDLE    = 2'd3
  } rcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_JOIN_TGT,
    S_WAKE_RD,
    S_WAKE_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_TGT,
    RD_IDX
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_CREATE,
    WR_SLEEP,
    WR_DONE,
    WR_WAKE
  } wr_sel_e;

  localparam int unsigned IdW   = 6;   // id width on the ports
  localparam int unsigned CmpW  = 16;  // common width for id compares

  // controller -> datapath
  typedef struct packed {
    logic    accept;     // latch event, remember old current thread
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    count_inc;  // create: bump thread count, record new id
    logic    code_wr;
    rcode_e  code;
    logic    wake_init;
    logic    wake_next;
    logic    scan_init;
    logic    scan_next;
    logic    scan_take;
    logic    out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic rd_run;      // entry just read is runnable
    logic table_full;
    logic tgt_ok;      // join target below thread count
    logic wake_hit;    // entry just read sleeps on current thread
    logic wake_last;
    logic scan_last;
    logic out_ready;
  } dp_stat_t;

endpackage

[rtl/core/rrts_dp.sv]
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: thread table memory (status and wait target), current
// thread, thread count, sweep/scan index and the output register.
// ----------------------------------------------------------------------------
module rrts_dp #(
  parameter int unsigned MAX_THREADS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrts_pkg::dp_cmd_t  cmd_i,
  output rrts_pkg::dp_stat_t stat_o,
  input  logic [1:0]         ev_cmd_i,
  input  logic [5:0]         ev_target_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         running_thread_o,
  output logic [5:0]         new_thread_o,
  output logic               switched_o,
  output logic [1:0]         result_code_o
);
  import rrts_pkg::*;

  localparam int unsigned IW = $clog2(MAX_THREADS);
  localparam int unsigned CW = $clog2(MAX_THREADS + 1);
  localparam int unsigned MW = 2 + IdW;

  // thread table, no reset; entries at or above the count are never read
  logic [MW-1:0] mem_q [MAX_THREADS];
  logic [MW-1:0] rdata_q;
  logic          rd0_q;
  logic          e0_wr_q;   // entry 0 written since reset

  logic [IW-1:0] cur_q, old_q, idx_q;
  logic [CW-1:0] count_q, count_d, k_q;
  cmd_e          cmd_q;
  logic [IdW-1:0] target_q;
  logic [IW-1:0] newid_q;
  rcode_e        code_q;

  logic          out_valid_q;
  logic [5:0]    out_run_q, out_new_q;
  logic          out_sw_q;
  logic [1:0]    out_code_q;

  logic [IW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_data;
  tstat_e        rd_stat;
  logic [IdW-1:0] rd_wait;
  logic [IW-1:0] cur_nxt, idx_nxt;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_CUR:  rd_addr = cur_q;
      RD_TGT:  rd_addr = IW'(target_q);
      default: rd_addr = idx_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_CREATE: begin
        wr_addr = count_q[IW-1:0];
        wr_data = {ST_RUN, {IdW{1'b0}}};
      end
      WR_SLEEP: begin
        wr_addr = cur_q;
        wr_data = {ST_SLEEP, target_q};
      end
      WR_DONE: begin
        wr_addr = cur_q;
        wr_data = {ST_DONE, {IdW{1'b0}}};
      end
      default: begin
        wr_addr = idx_q;
        wr_data = {ST_RUN, {IdW{1'b0}}};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
      rd0_q   <= (rd_addr == '0);
    end
  end

  // thread 0 reads as runnable until its entry is first written
  always_comb begin
    rd_stat = tstat_e'(rdata_q[MW-1 -: 2]);
    if (rd0_q && !e0_wr_q) begin
      rd_stat = ST_RUN;
    end
    rd_wait = rdata_q[IdW-1:0];
  end

  assign count_d = cmd_i.count_inc ? count_q + CW'(1) : count_q;
  // cyclic successor, wrapping at the (possibly just grown) thread count
  assign cur_nxt = ((CW'(cur_q) + CW'(1)) == count_d) ? '0 : cur_q + IW'(1);
  assign idx_nxt = ((CW'(idx_q) + CW'(1)) == count_q) ? '0 : idx_q + IW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      count_q     <= CW'(1);
      e0_wr_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.wr_en && wr_addr == '0) begin
        e0_wr_q <= 1'b1;
      end
      if (cmd_i.scan_take) begin
        cur_q <= idx_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q    <= cmd_e'(ev_cmd_i);
      target_q <= ev_target_i;
      old_q    <= cur_q;
      newid_q  <= '0;
      code_q   <= RC_OK;
    end
    if (cmd_i.count_inc) begin
      newid_q <= count_q[IW-1:0];
    end
    if (cmd_i.code_wr) begin
      code_q <= cmd_i.code;
    end
    if (cmd_i.wake_init) begin
      idx_q <= '0;
    end else if (cmd_i.wake_next) begin
      idx_q <= idx_q + IW'(1);
    end else if (cmd_i.scan_init) begin
      idx_q <= cur_nxt;
      k_q   <= CW'(1);
    end else if (cmd_i.scan_next) begin
      idx_q <= idx_nxt;
      k_q   <= k_q + CW'(1);
    end
    if (cmd_i.out_load) begin
      out_run_q  <= IdW'(cur_q);
      out_new_q  <= IdW'(newid_q);
      out_sw_q   <= (cur_q != old_q);
      out_code_q <= code_q;
    end
  end

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.rd_run     = (rd_stat == ST_RUN);
    stat_o.table_full = (count_q == CW'(MAX_THREADS));
    stat_o.tgt_ok     = (CmpW'(target_q) < CmpW'(count_q));
    stat_o.wake_hit   = (rd_stat == ST_SLEEP) && (CmpW'(rd_wait) == CmpW'(cur_q));
    stat_o.wake_last  = ((CW'(idx_q) + CW'(1)) == count_q);
    stat_o.scan_last  = (k_q == count_q);
    stat_o.out_ready  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign running_thread_o = out_run_q;
  assign new_thread_o     = out_new_q;
  assign switched_o       = out_sw_q;
  assign result_code_o    = out_code_q;

endmodule

[rtl/core/rrts_ctrl.sv]
// ----------------------------------------------------------------------------
// rrts_ctrl
// Scheduler controller: sequences table reads and writes for one event,
// the wake sweep on exit and the cyclic runnable search.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rrts_pkg::dp_stat_t stat_i,
  output rrts_pkg::dp_cmd_t  cmd_o
);
  import rrts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CUR;
      end
      S_CUR: begin
        unique case (stat_i.cmd)
          CMD_CREATE: state_d = stat_i.table_full ? S_DONE : S_SCAN_RD;
          CMD_JOIN:   state_d = (stat_i.rd_run && stat_i.tgt_ok) ? S_JOIN_TGT : S_DONE;
          CMD_EXIT:   state_d = stat_i.rd_run ? S_WAKE_RD : S_SCAN_RD;
          default:    state_d = S_SCAN_RD;
        endcase
      end
      S_JOIN_TGT: state_d = stat_i.rd_run ? S_SCAN_RD : S_DONE;
      S_WAKE_RD:  state_d = S_WAKE_CHK;
      S_WAKE_CHK: state_d = stat_i.wake_last ? S_SCAN_RD : S_WAKE_RD;
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (stat_i.rd_run || stat_i.scan_last) state_d = S_DONE;
        else state_d = S_SCAN_RD;
      end
      S_DONE: begin
        if (stat_i.out_ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_CUR;
    cmd_o.wr_sel = WR_CREATE;
    cmd_o.code   = RC_OK;
    in_stall_o   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        cmd_o.rd_en  = in_valid_i;
      end
      S_CUR: begin
        unique case (stat_i.cmd)
          CMD_CREATE: begin
            if (stat_i.table_full) begin
              cmd_o.code_wr = 1'b1;
              cmd_o.code    = RC_FULL;
            end else begin
              cmd_o.wr_en     = 1'b1;
              cmd_o.wr_sel    = WR_CREATE;
              cmd_o.count_inc = 1'b1;
              cmd_o.scan_init = 1'b1;
            end
          end
          CMD_JOIN: begin
            if (stat_i.rd_run && stat_i.tgt_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_TGT;
            end else begin
              cmd_o.code_wr = 1'b1;
              cmd_o.code    = RC_NO_JOIN;
            end
          end
          CMD_EXIT: begin
            if (stat_i.rd_run) begin
              cmd_o.wr_en     = 1'b1;
              cmd_o.wr_sel    = WR_DONE;
              cmd_o.wake_init = 1'b1;
            end else begin
              cmd_o.scan_init = 1'b1;
            end
          end
          default: cmd_o.scan_init = 1'b1;
        endcase
      end
      S_JOIN_TGT: begin
        if (stat_i.rd_run) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = WR_SLEEP;
          cmd_o.scan_init = 1'b1;
        end else begin
          cmd_o.code_wr = 1'b1;
          cmd_o.code    = RC_NO_JOIN;
        end
      end
      S_WAKE_RD, S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_IDX;
      end
      S_WAKE_CHK: begin
        cmd_o.wr_en  = stat_i.wake_hit;
        cmd_o.wr_sel = WR_WAKE;
        if (stat_i.wake_last) cmd_o.scan_init = 1'b1;
        else cmd_o.wake_next = 1'b1;
      end
      S_SCAN_CHK: begin
        if (stat_i.rd_run) begin
          cmd_o.scan_take = 1'b1;
        end else if (stat_i.scan_last) begin
          cmd_o.code_wr = 1'b1;
          cmd_o.code    = RC_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_DONE: cmd_o.out_load = stat_i.out_ready;
      default: ;
    endcase
  end

endmodule

[rtl/core/round_robin_thread_scheduler_top.sv]
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top
// Round-robin hardware thread scheduler with create, join and exit.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_stall_o) carries one event per transaction:
// cmd_i and target_thread_i. Output channel (out_valid_o/out_stall_i)
// carries one result per event: running_thread_o, new_thread_o, switched_o
// and result_code_o.
// One event is processed at a time; in_stall_o is high from acceptance until
// the result is loaded into the output register. The thread table is a
// single-port memory read one entry per access, so latency is set by the
// runnable search and the exit wake sweep. Each event reads the current
// thread's entry, a valid join also its target. An exit of a runnable thread
// sweeps every entry below the thread count to wake its waiters. Unless
// the event fails, the search then reads ids cyclically from the one
// after the current thread, for at most the thread count. The output
// register lets a new event be accepted while the previous result waits.
// A stalled receiver holds the result; the next result then waits in the
// controller until the output register frees. After reset, thread 0 is
// runnable and current and the thread count is 1; no clearing pass is
// needed, so events are accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_top #(
  parameter int unsigned MAX_THREADS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [5:0] target_thread_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] running_thread_o,
  output logic [5:0] new_thread_o,
  output logic       switched_o,
  output logic [1:0] result_code_o
);
  import rrts_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  rrts_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .ev_cmd_i         (cmd_i),
    .ev_target_i      (target_thread_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .running_thread_o (running_thread_o),
    .new_thread_o     (new_thread_o),
    .switched_o       (switched_o),
    .result_code_o    (result_code_o)
  );

endmodule

[rtl/core/rrts_checker.sv]
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the thread scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] running_thread_o,
  input logic [5:0] new_thread_o,
  input logic       switched_o,
  input logic [1:0] result_code_o
);
  import rrts_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(running_thread_o)
      && $stable(new_thread_o) && $stable(switched_o) && $stable(result_code_o))
    else $error("stalled result changed");

  // a failed create changes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_code_o == RC_FULL |-> !switched_o && new_thread_o == '0)
    else $error("full table result not clean");

  // a no-op join neither switches nor allocates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_code_o == RC_NO_JOIN |-> !switched_o && new_thread_o == '0)
    else $error("no-op join result not clean");

  // idle keeps the current thread
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_code_o == RC_IDLE |-> !switched_o)
    else $error("switch reported while idle");

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .running_thread_o (running_thread_o),
  .new_thread_o     (new_thread_o),
  .switched_o       (switched_o),
  .result_code_o    (result_code_o)
);

[sim/tb_round_robin_thread_scheduler_top.sv]
// ----------------------------------------------------------------------------
// tb_round_robin_thread_scheduler_top
// Self-checking bench for the round-robin thread scheduler. An event-level
// scheduler model predicts each result at input acceptance. Results are
// compared field by field, in order. Stimulus: a directed walk through
// idle, join and exit corner cases, then a weighted random mix. After that
// the table is filled to its limit and every thread is retired to idle.
// Both handshakes idle and stall at random, except in a calm phase of the mix.
// ----------------------------------------------------------------------------
module tb_round_robin_thread_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 64;
  localparam int unsigned RANDOM_ITEMS  = 480;
  localparam int unsigned CREATE_CAP    = 60;   // keep table headroom during the random mix
  localparam int unsigned IDLE_PCT      = 37;
  localparam int unsigned SETTLE_CYCLES = 300;  // covers the slowest event, an exit
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [5:0] running;
    logic [5:0] new_id;
    logic       switched;
    rcode_e     code;
  } sched_result_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [1:0] cmd_i           = CMD_TICK;
  logic [5:0] target_thread_i = '0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [5:0] running_thread_o;
  logic [5:0] new_thread_o;
  logic       switched_o;
  logic [1:0] result_code_o;

  // scheduler model state
  tstat_e      thread_state [TABLE_DEPTH];
  logic [5:0]  waits_on     [TABLE_DEPTH];
  int unsigned cur_id;
  int unsigned live_count;
  int          runnable_ids [$];

  sched_result_t pending_decisions [$];
  int            mismatch_count = 0;
  int            results_seen   = 0;
  logic          calm_mode      = 1'b0;

  round_robin_thread_scheduler_top #(
    .MAX_THREADS (TABLE_DEPTH)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .target_thread_i  (target_thread_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .running_thread_o (running_thread_o),
    .new_thread_o     (new_thread_o),
    .switched_o       (switched_o),
    .result_code_o    (result_code_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm_mode && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Applies one event to the model and returns the result it produces.
  function automatic sched_result_t schedule_event(input cmd_e op, input logic [5:0] tgt);
    int unsigned   prev;
    int unsigned   idx;
    logic          cur_runnable;
    logic          resched;
    logic          found;
    sched_result_t res;
    prev         = cur_id;
    res.new_id   = '0;
    res.code     = RC_OK;
    resched      = 1'b1;
    found        = 1'b0;
    cur_runnable = (thread_state[cur_id] == ST_RUN);
    case (op)
      CMD_CREATE: begin
        if (live_count >= TABLE_DEPTH) begin
          res.code = RC_FULL;
          resched  = 1'b0;
        end else begin
          res.new_id               = live_count[5:0];
          thread_state[live_count] = ST_RUN;
          live_count++;
        end
      end
      CMD_JOIN: begin
        if (cur_runnable && tgt < live_count && thread_state[tgt] == ST_RUN) begin
          thread_state[cur_id] = ST_SLEEP;
          waits_on[cur_id]     = tgt;
        end else begin
          res.code = RC_NO_JOIN;
          resched  = 1'b0;
        end
      end
      CMD_EXIT: begin
        if (cur_runnable) begin
          thread_state[cur_id] = ST_DONE;
          for (int unsigned i = 0; i < live_count; i++) begin
            if (thread_state[i] == ST_SLEEP && waits_on[i] == cur_id[5:0]) begin
              thread_state[i] = ST_RUN;
            end
          end
        end
      end
      default: ;
    endcase
    if (resched) begin
      // search starts after the current id; the current id is checked last
      for (int unsigned k = 1; k <= live_count; k++) begin
        idx = (prev + k) % live_count;
        if (!found && thread_state[idx] == ST_RUN) begin
          cur_id = idx;
          found  = 1'b1;
        end
      end
      if (!found) res.code = RC_IDLE;
    end
    res.running  = cur_id[5:0];
    res.switched = (cur_id != prev);
    return res;
  endfunction

  function automatic void collect_runnable();
    runnable_ids.delete();
    for (int unsigned i = 0; i < live_count; i++) begin
      if (thread_state[i] == ST_RUN) runnable_ids.push_back(i);
    end
  endfunction

  // Result checker: the oldest prediction goes with each accepted result.
  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_decisions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("result %0d arrived with no event pending:", results_seen,
                   " run %0d new %0d sw %0b code %0d",
                   running_thread_o, new_thread_o, switched_o, result_code_o);
        end
      end else begin
        want = pending_decisions.pop_front();
        if (running_thread_o !== want.running || new_thread_o !== want.new_id ||
            switched_o !== want.switched || result_code_o !== want.code) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d mismatch:", results_seen,
                     " expected run %0d new %0d sw %0b code %0d,",
                     want.running, want.new_id, want.switched, want.code,
                     " got run %0d new %0d sw %0b code %0d",
                     running_thread_o, new_thread_o, switched_o, result_code_o);
          end
        end
      end
    end
  end

  // One input transaction, with random idle cycles ahead of it outside calm mode.
  task automatic send_event(input cmd_e op, input logic [5:0] tgt);
    if (!calm_mode) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= op;
    target_thread_i <= tgt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_decisions.push_back(schedule_event(op, tgt));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_sequence();
    send_event(CMD_TICK,   6'd63);  // lone thread keeps running
    send_event(CMD_JOIN,   6'd0);   // join on self: sleeps forever, block goes idle
    send_event(CMD_TICK,   6'd0);
    send_event(CMD_JOIN,   6'd0);   // join while idle
    send_event(CMD_EXIT,   6'd42);  // exit while idle only reschedules
    send_event(CMD_CREATE, 6'd21);  // wakes the block up on thread 1
    send_event(CMD_CREATE, 6'd0);
    send_event(CMD_JOIN,   6'd63);  // target beyond the thread count
    send_event(CMD_JOIN,   6'd0);   // target asleep
    send_event(CMD_JOIN,   6'd5);   // target unused
    send_event(CMD_CREATE, 6'd63);
    send_event(CMD_JOIN,   6'd1);
    send_event(CMD_TICK,   6'd0);
    send_event(CMD_JOIN,   6'd1);   // two threads now wait on thread 1
    send_event(CMD_EXIT,   6'd0);   // wakes both waiters
    send_event(CMD_JOIN,   6'd1);   // target finished
    send_event(CMD_EXIT,   6'd63);
    send_event(CMD_TICK,   6'd0);   // only the current thread is left runnable
    send_event(CMD_EXIT,   6'd0);   // nothing runnable afterwards
    send_event(CMD_CREATE, 6'd42);
    send_event(CMD_TICK,   6'd21);
    drain_results();
  endtask

  task automatic test_random_mix();
    int unsigned roll;
    int unsigned pick;
    logic [5:0]  tgt;
    cmd_e        op;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) calm_mode <= 1'b1;
      if (n == 300) calm_mode <= 1'b0;
      if (n == 420) drain_results();
      collect_runnable();
      roll = $urandom_range(0, 99);
      tgt  = 6'($urandom_range(0, 63));
      if (live_count < CREATE_CAP && (roll < 6 || (runnable_ids.size() < 2 && roll < 60))) begin
        send_event(CMD_CREATE, tgt);
      end else if (roll < 40) begin
        send_event(CMD_TICK, tgt);
      end else if (roll < 72) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          tgt = cur_id[5:0];
        end else if (pick < 16 && runnable_ids.size() > 0) begin
          tgt = 6'(runnable_ids[$urandom_range(0, runnable_ids.size() - 1)]);
        end
        send_event(CMD_JOIN, tgt);
      end else if (roll < 82) begin
        send_event(CMD_EXIT, tgt);
      end else begin
        op = cmd_e'($urandom_range(0, 3));
        if (op == CMD_CREATE && live_count >= CREATE_CAP) op = CMD_TICK;
        send_event(op, tgt);
      end
    end
    drain_results();
  endtask

  task automatic test_table_full();
    while (live_count < TABLE_DEPTH) send_event(CMD_CREATE, 6'($urandom_range(0, 63)));
    repeat (3) send_event(CMD_CREATE, 6'd63);
    send_event(CMD_JOIN, 6'd63);
    send_event(CMD_TICK, 6'd0);
    drain_results();
  endtask

  task automatic test_drain_to_idle();
    int unsigned guard;
    guard = 0;
    collect_runnable();
    while (runnable_ids.size() > 0 && guard < 4 * TABLE_DEPTH) begin
      send_event(CMD_EXIT, 6'($urandom_range(0, 63)));
      collect_runnable();
      guard++;
    end
    send_event(CMD_TICK,   6'd0);
    send_event(CMD_JOIN,   6'd0);
    send_event(CMD_EXIT,   6'd63);
    send_event(CMD_CREATE, 6'd0);   // full table while idle
    send_event(CMD_JOIN,   6'd63);
    drain_results();
  endtask

  initial begin
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      thread_state[i] = ST_UNUSED;
      waits_on[i]     = '0;
    end
    thread_state[0] = ST_RUN;
    cur_id          = 0;
    live_count      = 1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_sequence();
    test_random_mix();
    test_table_full();
    test_drain_to_idle();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_decisions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rrts_pkg.sv
rtl/core/rrts_dp.sv
rtl/core/rrts_ctrl.sv
rtl/core/round_robin_thread_scheduler_top.sv
rtl/core/rrts_checker.sv
sim/tb_round_robin_thread_scheduler_top.sv
